// ===== src/windowed_swing_detector_core_defines.svh =====
// Assertion macros shared by the windowed swing detector checker.
`ifndef WINDOWED_SWING_DETECTOR_CORE_DEFINES_SVH
`define WINDOWED_SWING_DETECTOR_CORE_DEFINES_SVH

// Checked on every rising clock edge once reset has been released.
`define WSD_ASSERT(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) expr) else $error(msg);

// Checked on every rising clock edge, including while reset is held.
`define WSD_ASSERT_ALWAYS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) expr) else $error(msg);

`endif

// ===== src/wsd_pkg.sv =====
// Shared types and constants of the windowed swing detector.
`timescale 1ns / 1ps
`default_nettype none
package wsd_pkg;

	localparam int THR_BITS       = 16;
	localparam int RUN_BITS       = 8;
	localparam int OPC_BITS       = 2;
	localparam int CFG_INDEX_BITS = 1;
	localparam int CFG_DATA_BITS  = 16;

	localparam logic [THR_BITS-1:0] THR_RESET = 16'd1024;
	localparam logic [RUN_BITS-1:0] RUN_RESET = 8'd1;

	typedef enum logic [OPC_BITS-1:0] {
		OP_PUSH  = 2'd0,
		OP_FILL  = 2'd1,
		OP_CLEAR = 2'd2
	} opcode_t;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		CFG_SWING_THRESHOLD = 1'd0,
		CFG_REQUIRED_RUN    = 1'd1
	} cfg_index_t;

	typedef struct packed {
		logic shift;
		logic load;
		logic clear;
	} cell_ctrl_t;

endpackage
`default_nettype wire

// ===== src/wsd_cell.sv =====
// One slot of the sample window: shifts from its neighbor, loads or clears.
`timescale 1ns / 1ps
`default_nettype none
module wsd_cell
	import wsd_pkg::*;
#(
	parameter int SAMPLE_BITS = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire cell_ctrl_t                    ctrl,
	input  wire logic signed [SAMPLE_BITS-1:0] shift_in,
	input  wire logic signed [SAMPLE_BITS-1:0] fill_value,
	output logic signed [SAMPLE_BITS-1:0]      value
);

	logic signed [SAMPLE_BITS-1:0] value_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			value_q <= '0;
		end else if (ctrl.clear) begin
			value_q <= '0;
		end else if (ctrl.load) begin
			value_q <= fill_value;
		end else if (ctrl.shift) begin
			value_q <= shift_in;
		end
	end

	assign value = value_q;

endmodule
`default_nettype wire

// ===== src/wsd_skid.sv =====
// Output register with a skid stage for the result channel.
`timescale 1ns / 1ps
`default_nettype none
module wsd_skid #(
	parameter int WIDTH = 27
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire logic [WIDTH-1:0] in_data,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic [WIDTH-1:0]      out_data
);

	logic             main_valid_q;
	logic             skid_valid_q;
	logic [WIDTH-1:0] main_q;
	logic [WIDTH-1:0] skid_q;
	logic             take;
	logic             acc;

	assign in_ready  = !skid_valid_q;
	assign out_valid = main_valid_q;
	assign out_data  = main_q;
	assign take      = main_valid_q & out_ready;
	assign acc       = in_valid & !skid_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (take) begin
				skid_valid_q <= 1'b0;
			end
		end else if (acc) begin
			if (!main_valid_q || take) begin
				main_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end else if (take) begin
			main_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q && take) begin
			main_q <= skid_q;
		end else if (acc && (!main_valid_q || take)) begin
			main_q <= in_data;
		end
		if (acc && main_valid_q && !take) begin
			skid_q <= in_data;
		end
	end

endmodule
`default_nettype wire

// ===== src/windowed_swing_detector_core.sv =====
// Top level of the windowed swing detector.
//
// Input channel (in_valid/in_ready) carries an opcode and a signed sample:
// push a sample, fill every window slot with the sample, or clear the window.
// Each transaction produces exactly one result transaction on the output
// channel (out_valid/out_ready): fire, window_full, fill_count, window_sum.
// The configuration channel (cfg_valid/cfg_ready) writes swing_threshold at
// index 0 and required_run at index 1; it is always ready and should only be
// used while no results are outstanding.
// Results are registered in the output stage. One item is taken per cycle
// while in_ready is high: the shift of the cell chain, the running-sum
// update and the deviation compare all complete in the cycle of acceptance.
// A skid stage behind the output register lets one further item be taken
// while a result is stalled; in_ready drops only when both are occupied.
// Reset empties the window, zeroes the sum, fill count and run counter,
// and restores the register defaults (threshold 1024, run length 1).
`timescale 1ns / 1ps
`default_nettype none
module windowed_swing_detector_core
	import wsd_pkg::*;
#(
	parameter int WINDOW      = 16,
	parameter int SAMPLE_BITS = 16,
	localparam int LOGW       = $clog2(WINDOW),
	localparam int SUM_BITS   = SAMPLE_BITS + LOGW,
	localparam int CNT_BITS   = $clog2(WINDOW + 1)
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [CFG_INDEX_BITS-1:0]     cfg_index,
	input  wire logic [CFG_DATA_BITS-1:0]      cfg_data,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [OPC_BITS-1:0]           opcode,
	input  wire logic signed [SAMPLE_BITS-1:0] sample,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic                               fire,
	output logic                               window_full,
	output logic [CNT_BITS-1:0]                fill_count,
	output logic signed [SUM_BITS-1:0]         window_sum
);

	localparam int DIFF_BITS = SUM_BITS + 1;
	localparam int LIM_BITS  = THR_BITS + LOGW;
	localparam int CMP_BITS  = (DIFF_BITS > LIM_BITS) ? DIFF_BITS : LIM_BITS;
	localparam int RES_BITS  = 2 + CNT_BITS + SUM_BITS;

	localparam logic signed [SUM_BITS-1:0] WIN_S    = SUM_BITS'(WINDOW);
	localparam logic [CNT_BITS-1:0]        WIN_CNT  = CNT_BITS'(WINDOW);
	localparam logic [CMP_BITS-1:0]        WIN_CMP  = CMP_BITS'(WINDOW);

	logic [THR_BITS-1:0]               thr_q;
	logic [RUN_BITS-1:0]               need_q;
	logic signed [SUM_BITS-1:0]        sum_q;
	logic [CNT_BITS-1:0]               count_q;
	logic [RUN_BITS-1:0]               run_q;

	logic signed [SAMPLE_BITS-1:0]     cell_val [WINDOW];
	cell_ctrl_t                        cell_ctrl;

	logic                              acc;
	logic signed [SUM_BITS-1:0]        s_ext;
	logic signed [SUM_BITS-1:0]        tail_ext;
	logic signed [SUM_BITS-1:0]        push_sum;
	logic signed [SUM_BITS-1:0]        fill_sum;
	logic [CNT_BITS-1:0]               push_cnt;
	logic                              push_full;
	logic signed [DIFF_BITS-1:0]       diff;
	logic [DIFF_BITS-1:0]              mag;
	logic [CMP_BITS-1:0]               limit;
	logic                              big;
	logic [RUN_BITS-1:0]               run_inc;
	logic [RUN_BITS-1:0]               need;
	logic                              fire_push;
	logic [RUN_BITS-1:0]               push_run;

	logic signed [SUM_BITS-1:0]        sum_d;
	logic [CNT_BITS-1:0]               count_d;
	logic [RUN_BITS-1:0]               run_d;
	logic                              fire_d;
	logic [RES_BITS-1:0]               res_data;
	logic [RES_BITS-1:0]               out_data;

	// Configuration registers.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q  <= THR_RESET;
			need_q <= RUN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index_t'(cfg_index))
				CFG_SWING_THRESHOLD: thr_q  <= cfg_data[THR_BITS-1:0];
				CFG_REQUIRED_RUN:    need_q <= cfg_data[RUN_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	assign acc = in_valid & in_ready;

	// Chain of cells: cell 0 holds the newest sample, the last cell the oldest.
	for (genvar i = 0; i < WINDOW; i++) begin : g_cell
		if (i == 0) begin : g_head
			wsd_cell #(
				.SAMPLE_BITS(SAMPLE_BITS)
			) u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.ctrl      (cell_ctrl),
				.shift_in  (sample),
				.fill_value(sample),
				.value     (cell_val[i])
			);
		end else begin : g_body
			wsd_cell #(
				.SAMPLE_BITS(SAMPLE_BITS)
			) u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.ctrl      (cell_ctrl),
				.shift_in  (cell_val[i-1]),
				.fill_value(sample),
				.value     (cell_val[i])
			);
		end
	end

	// Push path: sum update, then the deviation test against the new mean.
	assign s_ext     = SUM_BITS'(sample);
	assign tail_ext  = SUM_BITS'(cell_val[WINDOW-1]);
	assign push_sum  = sum_q - tail_ext + s_ext;
	assign fill_sum  = s_ext * WIN_S;
	assign push_cnt  = (count_q < WIN_CNT) ? count_q + CNT_BITS'(1) : count_q;
	assign push_full = (push_cnt == WIN_CNT);
	assign diff      = DIFF_BITS'(fill_sum) - DIFF_BITS'(push_sum);
	assign mag       = diff[DIFF_BITS-1] ? DIFF_BITS'(-diff) : DIFF_BITS'(diff);
	assign limit     = CMP_BITS'(thr_q) * WIN_CMP;
	assign big       = (CMP_BITS'(mag) > limit);
	assign run_inc   = run_q + RUN_BITS'(1);
	assign need      = (need_q == '0) ? RUN_BITS'(1) : need_q;
	assign fire_push = push_full & big & (run_inc >= need);

	always_comb begin
		if (!push_full) begin
			push_run = run_q;
		end else if (big && !fire_push) begin
			push_run = run_inc;
		end else begin
			push_run = '0;
		end
	end

	always_comb begin
		sum_d     = sum_q;
		count_d   = count_q;
		run_d     = run_q;
		fire_d    = 1'b0;
		cell_ctrl = '0;
		case (opcode_t'(opcode))
			OP_PUSH: begin
				sum_d           = push_sum;
				count_d         = push_cnt;
				run_d           = push_run;
				fire_d          = fire_push;
				cell_ctrl.shift = acc;
			end
			OP_FILL: begin
				sum_d          = fill_sum;
				count_d        = WIN_CNT;
				run_d          = '0;
				cell_ctrl.load = acc;
			end
			OP_CLEAR: begin
				sum_d           = '0;
				count_d         = '0;
				run_d           = '0;
				cell_ctrl.clear = acc;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= '0;
			count_q <= '0;
			run_q   <= '0;
		end else if (acc) begin
			sum_q   <= sum_d;
			count_q <= count_d;
			run_q   <= run_d;
		end
	end

	assign res_data = {fire_d, (count_d == WIN_CNT), count_d, sum_d};

	wsd_skid #(
		.WIDTH(RES_BITS)
	) u_skid (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (res_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	assign fire        = out_data[RES_BITS-1];
	assign window_full = out_data[RES_BITS-2];
	assign fill_count  = out_data[SUM_BITS +: CNT_BITS];
	assign window_sum  = out_data[SUM_BITS-1:0];

endmodule
`default_nettype wire

// ===== src/wsd_checker.sv =====
// Port-level checker for the windowed swing detector, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "windowed_swing_detector_core_defines.svh"
module wsd_checker #(
	parameter int WINDOW      = 16,
	parameter int SAMPLE_BITS = 16,
	localparam int SUM_BITS   = SAMPLE_BITS + $clog2(WINDOW),
	localparam int CNT_BITS   = $clog2(WINDOW + 1)
) (
	input wire logic                       clk,
	input wire logic                       arst_n,
	input wire logic                       out_valid,
	input wire logic                       out_ready,
	input wire logic                       fire,
	input wire logic                       window_full,
	input wire logic [CNT_BITS-1:0]        fill_count,
	input wire logic signed [SUM_BITS-1:0] window_sum
);

	localparam logic [CNT_BITS-1:0] WIN_CNT = CNT_BITS'(WINDOW);

	// A stalled result must stay valid and hold window_sum and fill_count until the transaction completes.
	`WSD_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(window_sum) && $stable(fill_count), "stalled result changed")
	`WSD_ASSERT_ALWAYS(a_reset_idle, !arst_n |-> !out_valid, "result valid during reset")
	`WSD_ASSERT(a_full_flag, out_valid |-> (window_full == (fill_count == WIN_CNT)), "window_full disagrees with fill_count")
	`WSD_ASSERT(a_fire_full, out_valid && fire |-> window_full, "fire while window not full")
	`WSD_ASSERT(a_count_range, out_valid |-> fill_count <= WIN_CNT, "fill_count above window size")

endmodule

bind windowed_swing_detector_core wsd_checker #(
	.WINDOW     (WINDOW),
	.SAMPLE_BITS(SAMPLE_BITS)
) u_wsd_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.fire       (fire),
	.window_full(window_full),
	.fill_count (fill_count),
	.window_sum (window_sum)
);
`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for the windowed swing detector core.
`timescale 1ns / 1ps
module tb;
	import wsd_pkg::*;

	localparam int WIN             = 16;
	localparam int DIR_ROWS        = 19;
	localparam int NUM_PHASES      = 8;
	localparam int ITEMS_PER_PHASE = 210;
	localparam int HOLD_CYCLES     = 80;
	localparam int WATCHDOG_LIMIT  = 4000;
	localparam int SETTLE_CYCLES   = 8;

	// Opcode value that the block leaves undefined and must ignore.
	localparam logic [OPC_BITS-1:0] OP_UNUSED = 2'd3;

	typedef struct packed {
		logic              fire;
		logic              full;
		logic [4:0]        cnt;
		logic signed [19:0] sum;
	} swing_res_t;

	typedef struct packed {
		logic [OPC_BITS-1:0] op;
		logic signed [15:0]  smp;
		logic                typed;
		swing_res_t          res;
	} stim_t;

	localparam swing_res_t NO_RES = '0;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [CFG_INDEX_BITS-1:0] cfg_index;
	logic [CFG_DATA_BITS-1:0]  cfg_data;
	logic                in_valid;
	logic                in_ready;
	logic [OPC_BITS-1:0] opcode;
	logic signed [15:0]  sample;
	logic                out_valid;
	logic                out_ready;
	logic                fire;
	logic                window_full;
	logic [4:0]          fill_count;
	logic signed [19:0]  window_sum;

	// Predictor state and register copies.
	logic signed [15:0] win_mem [WIN];
	int win_sum;
	int win_cnt;
	int run_len;
	int wr_pos;
	int thr_reg;
	int run_reg;

	stim_t      offered_q [$];
	swing_res_t window_exp_q [$];
	int         sent_cnt;
	int         res_cnt;
	int         err_cnt;
	int         burst_left;
	int         stall_cycles;
	stim_t      dir_tab [DIR_ROWS];

	windowed_swing_detector_core u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.opcode     (opcode),
		.sample     (sample),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.fire       (fire),
		.window_full(window_full),
		.fill_count (fill_count),
		.window_sum (window_sum)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic swing_res_t swing_predict(logic [OPC_BITS-1:0] op,
			logic signed [15:0] smp);
		swing_res_t r;
		int dev;
		int need;
		r.fire = 1'b0;
		case (op)
			OP_PUSH: begin
				win_sum = win_sum - int'(win_mem[wr_pos]) + int'(smp);
				win_mem[wr_pos] = smp;
				wr_pos = (wr_pos + 1) % WIN;
				if (win_cnt < WIN)
					win_cnt++;
				if (win_cnt == WIN) begin
					// Mean test without division: |WIN*s - sum| > WIN*thr.
					dev = WIN * int'(smp) - win_sum;
					if (dev < 0)
						dev = -dev;
					if (dev > WIN * thr_reg) begin
						need = (run_reg == 0) ? 1 : run_reg;
						run_len = (run_len + 1) & 255;
						if (run_len >= need) begin
							run_len = 0;
							r.fire = 1'b1;
						end
					end else begin
						run_len = 0;
					end
				end
			end
			OP_FILL: begin
				foreach (win_mem[i])
					win_mem[i] = smp;
				win_sum = WIN * int'(smp);
				win_cnt = WIN;
				wr_pos = 0;
				run_len = 0;
			end
			OP_CLEAR: begin
				foreach (win_mem[i])
					win_mem[i] = '0;
				win_sum = 0;
				win_cnt = 0;
				wr_pos = 0;
				run_len = 0;
			end
			default: ;
		endcase
		r.full = (win_cnt == WIN);
		r.cnt  = 5'(win_cnt);
		r.sum  = 20'(win_sum);
		return r;
	endfunction

	// Offers one item in bursts with random gaps; returns at its acceptance edge.
	task automatic offer_item(input stim_t it);
		int gap;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		offered_q.push_back(it);
		in_valid <= 1'b1;
		opcode   <= it.op;
		sample   <= it.smp;
		do @(posedge clk); while (!in_ready);
		sent_cnt++;
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (res_cnt != sent_cnt);
	endtask

	task automatic program_regs(input logic [15:0] thr, input logic [7:0] run);
		cfg_valid <= 1'b1;
		cfg_index <= CFG_SWING_THRESHOLD;
		cfg_data  <= thr;
		do @(posedge clk); while (!cfg_ready);
		// Upper data bits are don't-care for the run length register.
		cfg_index <= CFG_REQUIRED_RUN;
		cfg_data  <= {8'($urandom_range(0, 255)), run};
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// Transaction monitor: output check first, then prediction of new input.
	always @(posedge clk) begin : monitor
		stim_t      it;
		swing_res_t r;
		swing_res_t e;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (window_exp_q.size() == 0) begin
					$error("result transaction with no expected result pending");
					err_cnt++;
				end else begin
					e = window_exp_q.pop_front();
					if (fire !== e.fire) begin
						$error("fire: expected %0d, actual %0d", e.fire, fire);
						err_cnt++;
					end
					if (window_full !== e.full) begin
						$error("window_full: expected %0d, actual %0d", e.full, window_full);
						err_cnt++;
					end
					if (fill_count !== e.cnt) begin
						$error("fill_count: expected %0d, actual %0d", e.cnt, fill_count);
						err_cnt++;
					end
					if (window_sum !== e.sum) begin
						$error("window_sum: expected %0d, actual %0d", e.sum, window_sum);
						err_cnt++;
					end
				end
				res_cnt++;
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_SWING_THRESHOLD: thr_reg = int'(cfg_data);
					CFG_REQUIRED_RUN:    run_reg = int'(cfg_data[RUN_BITS-1:0]);
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				it = offered_q.pop_front();
				r = swing_predict(opcode, sample);
				window_exp_q.push_back(it.typed ? it.res : r);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) ||
					(cfg_valid && cfg_ready)) begin
				stall_cycles = 0;
			end else begin
				stall_cycles++;
				if (stall_cycles >= WATCHDOG_LIMIT) begin
					$display("FAILURE");
					$finish;
				end
			end
		end
	end

	// Result side: stall patterns in segments, plus two long hold-offs.
	initial begin : receiver
		int seg_len;
		int mode;
		int rx_cnt;
		int hold_idx;
		int hold_at [2];
		rx_cnt   = 0;
		hold_idx = 0;
		hold_at  = '{300, 1200};
		out_ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			seg_len = $urandom_range(8, 64);
			mode    = $urandom_range(0, 2);
			repeat (seg_len) begin
				@(posedge clk);
				if (out_valid && out_ready)
					rx_cnt++;
				if (hold_idx < 2 && rx_cnt >= hold_at[hold_idx]) begin
					hold_idx++;
					out_ready <= 1'b0;
					repeat (HOLD_CYCLES) @(posedge clk);
				end else begin
					case (mode)
						0: out_ready <= 1'b1;
						1: out_ready <= 1'($urandom_range(0, 1));
						default: out_ready <= ($urandom_range(0, 3) == 0);
					endcase
				end
			end
		end
	end

	initial begin : stimulus
		stim_t it;
		logic [15:0] thr;
		logic [7:0]  run;
		int amp;
		int base;
		int spike_left;
		int pick;
		int v;
		arst_n    <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= CFG_SWING_THRESHOLD;
		cfg_data  <= '0;
		in_valid  <= 1'b0;
		opcode    <= OP_PUSH;
		sample    <= '0;
		foreach (win_mem[i])
			win_mem[i] = '0;
		win_sum      = 0;
		win_cnt      = 0;
		run_len      = 0;
		wr_pos       = 0;
		thr_reg      = int'(THR_RESET);
		run_reg      = int'(RUN_RESET);
		sent_cnt     = 0;
		res_cnt      = 0;
		err_cnt      = 0;
		burst_left   = 0;
		stall_cycles = 0;

		dir_tab = '{
			'{OP_PUSH,   16'h0000, 1'b1, '{1'b0, 1'b0, 5'd1,  20'd0}},
			'{OP_PUSH,   16'h7FFF, 1'b1, '{1'b0, 1'b0, 5'd2,  20'd32767}},
			'{OP_PUSH,   16'h8000, 1'b1, '{1'b0, 1'b0, 5'd3,  20'hFFFFF}},
			'{OP_UNUSED, 16'h5555, 1'b1, '{1'b0, 1'b0, 5'd3,  20'hFFFFF}},
			'{OP_CLEAR,  16'h7FFF, 1'b1, '{1'b0, 1'b0, 5'd0,  20'd0}},
			'{OP_UNUSED, 16'hFFFF, 1'b1, '{1'b0, 1'b0, 5'd0,  20'd0}},
			'{OP_FILL,   16'h7FFF, 1'b1, '{1'b0, 1'b1, 5'd16, 20'd524272}},
			'{OP_PUSH,   16'h7FFF, 1'b1, '{1'b0, 1'b1, 5'd16, 20'd524272}},
			'{OP_PUSH,   16'h8000, 1'b0, NO_RES},
			'{OP_UNUSED, 16'h0000, 1'b0, NO_RES},
			'{OP_FILL,   16'h8000, 1'b1, '{1'b0, 1'b1, 5'd16, 20'h80000}},
			'{OP_PUSH,   16'h8000, 1'b1, '{1'b0, 1'b1, 5'd16, 20'h80000}},
			'{OP_PUSH,   16'h7FFF, 1'b0, NO_RES},
			'{OP_FILL,   16'h0000, 1'b1, '{1'b0, 1'b1, 5'd16, 20'd0}},
			'{OP_PUSH,   16'd1024, 1'b0, NO_RES},
			'{OP_PUSH,   -16'sd1100, 1'b0, NO_RES},
			'{OP_PUSH,   16'd2000, 1'b0, NO_RES},
			'{OP_CLEAR,  16'h0000, 1'b1, '{1'b0, 1'b0, 5'd0,  20'd0}},
			'{OP_PUSH,   -16'sd5,  1'b0, NO_RES}
		};

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed rows run with the register reset values.
		foreach (dir_tab[i])
			offer_item(dir_tab[i]);

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			drain_results();
			case (ph)
				0: begin thr = 16'd0;     run = 8'd1;   end
				1: begin thr = 16'hFFFF;  run = 8'd255; end
				2: begin thr = 16'd0;     run = 8'd0;   end
				3: begin thr = 16'd300;   run = 8'd3;   end
				4: begin thr = 16'd2000;  run = 8'd2;   end
				5: begin thr = THR_RESET; run = RUN_RESET; end
				default: begin
					thr = 16'($urandom_range(0, 4000));
					run = 8'($urandom_range(1, 5));
				end
			endcase
			program_regs(thr, run);
			amp        = $urandom_range(0, 3000);
			base       = int'($urandom_range(0, 16000)) - 8000;
			spike_left = 0;
			repeat (ITEMS_PER_PHASE) begin
				pick = $urandom_range(0, 99);
				if (pick < 2)
					it.op = OP_CLEAR;
				else if (pick < 6)
					it.op = OP_FILL;
				else if (pick < 8)
					it.op = OP_UNUSED;
				else
					it.op = OP_PUSH;
				if ($urandom_range(0, 63) == 0)
					base = int'($urandom_range(0, 16000)) - 8000;
				// Runs of large swings so that longer run lengths can complete.
				if (spike_left != 0) begin
					spike_left--;
					v = base + (($urandom_range(0, 1) == 1) ? 1 : -1) *
						int'($urandom_range(5000, 24000));
					it.smp = 16'(v);
				end else if ($urandom_range(0, 9) == 0) begin
					spike_left = $urandom_range(0, 6);
					v = base + int'($urandom_range(5000, 24000));
					it.smp = 16'(v);
				end else if ($urandom_range(0, 9) == 0) begin
					it.smp = 16'($urandom);
				end else begin
					v = base + int'($urandom_range(0, 2 * amp)) - amp;
					it.smp = 16'(v);
				end
				it.typed = 1'b0;
				it.res   = NO_RES;
				offer_item(it);
			end
		end

		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (err_cnt == 0 && window_exp_q.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
